// File: rtl/lfuc_pkg.sv
// Package for the LFU write-back block cache: sizes, command and result codes,
// payload structs and the command/status structs between controller and datapath.
// Depends on nothing.
package lfuc_pkg;

    localparam int ENTRIES      = 16;
    localparam int ENT_W        = $clog2(ENTRIES);
    localparam int INDEX_WIDTH  = 32;
    localparam int COUNT_WIDTH  = 16;
    localparam int DATA_WIDTH   = 64;
    localparam int OFFSET_WIDTH = 48;
    localparam int BSIZE_WIDTH  = 17;
    localparam int CAP_WIDTH    = 5;
    localparam int USED_W       = ENT_W + 1;

    // Command codes.
    localparam logic [2:0] CMD_READ  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_FILL  = 3'd2;
    localparam logic [2:0] CMD_FLUSH = 3'd3;
    localparam logic [2:0] CMD_CLOSE = 3'd4;

    // Result kinds.
    localparam logic [2:0] KIND_READ_HIT  = 3'd0;
    localparam logic [2:0] KIND_READ_MISS = 3'd1;
    localparam logic [2:0] KIND_WRITE     = 3'd2;
    localparam logic [2:0] KIND_FILL      = 3'd3;
    localparam logic [2:0] KIND_FLUSH_WB  = 3'd4;
    localparam logic [2:0] KIND_FLUSH_END = 3'd5;

    // Configuration register indexes.
    localparam logic [0:0] REG_CAPACITY   = 1'd0;
    localparam logic [0:0] REG_BLOCK_SIZE = 1'd1;

    localparam logic [CAP_WIDTH-1:0]   CAP_RESET   = CAP_WIDTH'(16);
    localparam logic [BSIZE_WIDTH-1:0] BSIZE_RESET = BSIZE_WIDTH'(4096);

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] block_index;
        logic [63:0] write_data;
        logic [3:0]  byte_count;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] read_data;
        logic        wb_valid;
        logic [31:0] wb_block;
        logic [47:0] wb_offset;
        logic [63:0] wb_data;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [0:0]  index;
        logic [16:0] data;
    } t_cfg_item;

    // Controller to datapath commands.
    typedef struct packed {
        logic             latch_in;   // capture the input item
        logic             scan_clr;   // restart the entry scan
        logic             scan_step;  // examine entry at scan pointer, advance
        logic             evict;      // drop the chosen victim, capture writeback
        logic             install;    // write or update the entry
        logic             wb_scan;    // capture writeback of scan entry, clear dirty
        logic             clear_all;  // close: invalidate everything
        logic             bump_hit;   // read hit: count a use
        logic [2:0]       out_kind;
        logic             out_wb;
        logic             out_last;
        logic             out_load;   // load the result register
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic [2:0] cmd;
        logic       scan_done;   // scan pointer passed the last entry
        logic       hit;         // a matching entry was found
        logic       full;        // valid entries reach capacity
        logic       have_victim;
        logic       victim_dirty;
        logic       cur_dirty;   // entry at scan pointer is valid and dirty
    } t_dp_sts;

    // Byte mask of the low n bytes, saturated at the word width.
    function automatic logic [DATA_WIDTH-1:0] byte_mask(input logic [3:0] n);
        logic [DATA_WIDTH-1:0] m;
        m = '0;
        for (int b = 0; b < DATA_WIDTH / 8; b++) begin
            if (4'(b) < n) begin
                m[b*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/lfuc_if.sv
// Valid/ready channel interface carrying one payload struct.
// The payload type is a parameter; depends on nothing.
interface lfuc_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/lfuc_ctrl.sv
// Controller state machine of the LFU cache: sequences scans, updates and results.
// Depends on lfuc_pkg for codes and the command/status structs.
module lfuc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_busy,
    output lfuc_pkg::t_dp_cmd o_cmd,
    input  lfuc_pkg::t_dp_sts i_sts
);
    import lfuc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_WB     = 3'd4;
    localparam logic [2:0] ST_END    = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = ST_SEARCH;
                end
            end
            // One entry per cycle: tag match, valid count and LFU victim.
            ST_SEARCH: begin
                if (i_sts.cmd == CMD_FLUSH || i_sts.cmd == CMD_CLOSE) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = ST_SCAN;
                end else if (i_sts.cmd > CMD_CLOSE) begin
                    n_state = ST_IDLE;
                end else if (i_sts.scan_done) begin
                    n_state = ST_DECIDE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_DECIDE: begin
                if (!i_out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_state        = ST_IDLE;
                    if (i_sts.cmd == CMD_READ) begin
                        o_cmd.out_kind = i_sts.hit ? KIND_READ_HIT : KIND_READ_MISS;
                        o_cmd.bump_hit = i_sts.hit;
                    end else begin
                        o_cmd.out_kind = (i_sts.cmd == CMD_WRITE) ? KIND_WRITE : KIND_FILL;
                        o_cmd.install  = 1'b1;
                        if (!i_sts.hit && i_sts.full && i_sts.have_victim) begin
                            o_cmd.evict  = 1'b1;
                            o_cmd.out_wb = i_sts.victim_dirty;
                        end
                    end
                end
            end
            // Flush walk: clean entries one per cycle; dirty ones wait to emit a writeback.
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_END;
                end else if (i_sts.cur_dirty) begin
                    n_state = ST_WB;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_WB: begin
                if (!i_out_busy) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_kind  = KIND_FLUSH_WB;
                    o_cmd.out_wb    = 1'b1;
                    o_cmd.wb_scan   = 1'b1;
                    o_cmd.scan_step = 1'b1;
                    n_state         = ST_SCAN;
                end
            end
            ST_END: begin
                if (!i_out_busy) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_kind  = KIND_FLUSH_END;
                    o_cmd.out_last  = 1'b1;
                    o_cmd.clear_all = (i_sts.cmd == CMD_CLOSE);
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    // An item is only taken when idle.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch_in |-> r_state == ST_IDLE)
        else $error("item accepted outside idle");
    // A result is never loaded while the output register is full.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_out_busy)
        else $error("result register overwritten");
    // A flush writeback always points at a valid dirty entry.
    a_wb_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB) |-> i_sts.cur_dirty)
        else $error("writeback without dirty entry");
`endif
endmodule

// File: rtl/lfuc_datapath.sv
// Datapath of the LFU cache: entry storage, scan pointer, victim tracking,
// offset multiply and the result register. Depends on lfuc_pkg.
module lfuc_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lfuc_pkg::t_in_item              i_item,
    input  logic [lfuc_pkg::CAP_WIDTH-1:0]  i_capacity,
    input  logic [lfuc_pkg::BSIZE_WIDTH-1:0] i_block_size,
    input  lfuc_pkg::t_dp_cmd               i_cmd,
    output lfuc_pkg::t_dp_sts               o_sts,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lfuc_pkg::t_out_item             o_out
);
    import lfuc_pkg::*;

    // Entry storage; valid and dirty reset, the rest written on install.
    logic [ENTRIES-1:0]     r_valid, r_dirty;
    logic [INDEX_WIDTH-1:0] r_tag   [ENTRIES];
    logic [COUNT_WIDTH-1:0] r_count [ENTRIES];
    logic [DATA_WIDTH-1:0]  r_word  [ENTRIES];

    t_in_item           r_in;
    logic [ENT_W:0]     r_ptr;
    logic               r_hit;
    logic [ENT_W-1:0]   r_hit_idx;
    logic [USED_W-1:0]  r_used;
    logic               r_have_vic;
    logic [ENT_W-1:0]   r_vic_idx;
    logic [COUNT_WIDTH-1:0] r_vic_cnt;
    logic               r_have_free;
    logic [ENT_W-1:0]   r_free_idx;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [ENT_W-1:0]       ptr_idx;
    logic [CAP_WIDTH-1:0]   cap_eff;
    logic [DATA_WIDTH-1:0]  bmask;
    logic [ENT_W-1:0]       wb_idx;
    logic [ENT_W-1:0]       ins_idx;
    logic                   cur_valid;

    assign ptr_idx   = r_ptr[ENT_W-1:0];
    assign cur_valid = r_valid[ptr_idx];
    assign bmask     = byte_mask(r_in.byte_count);
    assign wb_idx    = i_cmd.wb_scan ? ptr_idx : r_vic_idx;

    // Capacity clamped to one through the entry count.
    always_comb begin
        if (i_capacity == '0) begin
            cap_eff = CAP_WIDTH'(1);
        end else if (i_capacity > CAP_WIDTH'(ENTRIES)) begin
            cap_eff = CAP_WIDTH'(ENTRIES);
        end else begin
            cap_eff = i_capacity;
        end
    end

    // New block: on evict the lower of victim and free slot, else free slot.
    always_comb begin
        if (r_hit) begin
            ins_idx = r_hit_idx;
        end else if (i_cmd.evict) begin
            ins_idx = (r_have_free && r_free_idx < r_vic_idx) ? r_free_idx : r_vic_idx;
        end else if (r_have_free) begin
            ins_idx = r_free_idx;
        end else begin
            ins_idx = '0;
        end
    end

    always_comb begin
        o_sts              = '0;
        o_sts.cmd          = r_in.cmd;
        o_sts.scan_done    = r_ptr[ENT_W];
        o_sts.hit          = r_hit;
        o_sts.full         = (CAP_WIDTH'(r_used) >= cap_eff);
        o_sts.have_victim  = r_have_vic;
        o_sts.victim_dirty = r_dirty[r_vic_idx];
        o_sts.cur_dirty    = cur_valid && r_dirty[ptr_idx];
    end

    // Scan pointer and per-item search state.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in <= i_item;
        end
        if (i_cmd.scan_clr) begin
            r_ptr       <= '0;
            r_hit       <= 1'b0;
            r_used      <= '0;
            r_have_vic  <= 1'b0;
            r_have_free <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_ptr <= r_ptr + 1'b1;
            if (!i_cmd.wb_scan) begin
                if (cur_valid) begin
                    r_used <= r_used + 1'b1;
                    if (r_tag[ptr_idx] == r_in.block_index && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= ptr_idx;
                    end
                    if (!r_have_vic || r_count[ptr_idx] < r_vic_cnt) begin
                        r_have_vic <= 1'b1;
                        r_vic_idx  <= ptr_idx;
                        r_vic_cnt  <= r_count[ptr_idx];
                    end
                end else if (!r_have_free) begin
                    r_have_free <= 1'b1;
                    r_free_idx  <= ptr_idx;
                end
            end
        end
    end

    // Entry updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
        end else if (i_cmd.clear_all) begin
            r_valid <= '0;
            r_dirty <= '0;
        end else begin
            if (i_cmd.wb_scan) begin
                r_dirty[ptr_idx] <= 1'b0;
            end
            if (i_cmd.evict) begin
                r_valid[r_vic_idx] <= 1'b0;
                r_dirty[r_vic_idx] <= 1'b0;
            end
            if (i_cmd.install) begin
                r_valid[ins_idx] <= 1'b1;
                if (r_in.cmd == CMD_WRITE) begin
                    r_dirty[ins_idx] <= 1'b1;
                end else if (!r_hit) begin
                    r_dirty[ins_idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.install) begin
            if (r_hit) begin
                r_word[ins_idx] <= (r_word[ins_idx] & ~bmask) | (r_in.write_data & bmask);
                if (r_count[ins_idx] != '1) begin
                    r_count[ins_idx] <= r_count[ins_idx] + 1'b1;
                end
            end else begin
                r_tag[ins_idx]   <= r_in.block_index;
                r_word[ins_idx]  <= r_in.write_data & bmask;
                r_count[ins_idx] <= COUNT_WIDTH'(1);
            end
        end else if (i_cmd.bump_hit && r_count[r_hit_idx] != '1) begin
            r_count[r_hit_idx] <= r_count[r_hit_idx] + 1'b1;
        end
    end

    // Result register; the offset is multiplied in place in the following cycle.
    logic r_mul_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_mul_pend  <= 1'b0;
        end else begin
            r_mul_pend <= i_cmd.out_load;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b0;
            end else if (r_mul_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.out_load) begin
            r_out.kind      <= i_cmd.out_kind;
            r_out.last      <= i_cmd.out_last;
            r_out.read_data <= (i_cmd.out_kind == KIND_READ_HIT) ?
                               (r_word[r_hit_idx] & bmask) : '0;
            r_out.wb_valid  <= i_cmd.out_wb;
            r_out.wb_block  <= i_cmd.out_wb ? r_tag[wb_idx] : '0;
            r_out.wb_data   <= i_cmd.out_wb ? r_word[wb_idx] : '0;
        end else if (r_mul_pend) begin
            r_out.wb_offset <= OFFSET_WIDTH'(r_out.wb_block) * OFFSET_WIDTH'(i_block_size);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    // The result stays stable while held.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && !i_cmd.out_load) |=> $stable(r_out))
        else $error("result changed while stalled");
    // A result without a writeback has a zero wb_block.
    a_wb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.wb_valid) |-> r_out.wb_block == '0)
        else $error("stray writeback fields");
    // Dirty implies valid.
    a_dirty_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dirty & ~r_valid) == '0)
        else $error("dirty entry not valid");
`endif
endmodule

// File: rtl/lfu_write_back_block_cache_core.sv
// LFU write-back block cache, fully associative, 16 entries of one 64-bit word.
// Channels: in (cmd, block_index, write_data, byte_count), out (kind,
// read_data, wb_valid, wb_block, wb_offset, wb_data, last) and cfg (index,
// data): all valid/ready, an item moves when both are high.
// Config registers: 0 capacity (reset 16), 1 block_size (reset 4096); write
// them only while the cache is idle.
// Each input item is processed alone. Read, write and fill walk all 16
// entries one per cycle for tag match, fill level and LFU victim, then
// produce one result once the output register is free: the result
// register is loaded and the offset multiply follows before it is valid,
// and a new item can be taken once the result is loaded. Flush and close
// walk the entries instead; each dirty entry adds a writeback result, and
// a writeback waits until the previous result has left the output register.
// The walk ends with a flush-done result; close then empties the cache.
// Results sit in an output register; when the receiver stalls the walk waits
// at the next result. Unknown commands produce nothing.
// Synchronous active-low reset empties the cache and restores both registers.
module lfu_write_back_block_cache_core (
    input logic   i_clk,
    input logic   i_rst_n,
    lfuc_if.sink   in_ch,
    lfuc_if.source out_ch,
    lfuc_if.sink   cfg_ch
);
    import lfuc_pkg::*;

    logic [CAP_WIDTH-1:0]   r_capacity;
    logic [BSIZE_WIDTH-1:0] r_block_size;
    t_dp_cmd                dp_cmd;
    t_dp_sts                dp_sts;
    logic                   out_valid;

    // Configuration registers.
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAP_RESET;
            r_block_size <= BSIZE_RESET;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.data.index)
                REG_CAPACITY:   r_capacity   <= cfg_ch.data.data[CAP_WIDTH-1:0];
                REG_BLOCK_SIZE: r_block_size <= cfg_ch.data.data;
                default: ;
            endcase
        end
    end

    lfuc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_out_busy (out_valid),
        .o_cmd      (dp_cmd),
        .i_sts      (dp_sts)
    );

    lfuc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (in_ch.data),
        .i_capacity   (r_capacity),
        .i_block_size (r_block_size),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ch.ready),
        .o_out        (out_ch.data)
    );

    assign out_ch.valid = out_valid;
endmodule
